// File: rtl/core/psmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psmc_pkg
// Types and constants shared by the proximity sensitivity mode controller.
// ----------------------------------------------------------------------------
package psmc_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [7:0] DeltaSat  = 8'h7F;
  localparam logic [7:0] DriftHigh = 8'h3F;
  localparam logic [7:0] ReturnLow = 8'h50;
  localparam logic [7:0] DeltaIdleLo = 8'h00;
  localparam logic [7:0] DeltaIdleHi = 8'hFF;
  localparam logic [7:0] CountMax  = 8'hFF;
  localparam logic [7:0] StatCh2   = 8'h02;
  localparam logic [7:0] StatCh6   = 8'h20;
  localparam logic [7:0] StatBoth  = 8'h22;

  typedef enum logic [0:0] {
    OP_ALERT = 1'b0,
    OP_CHECK = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SENSOR_ENABLE    = 2'd0,
    CFG_ACCUMULATE_LIMIT = 2'd1,
    CFG_DRIFT_LOW_CH2    = 2'd2,
    CFG_DRIFT_LOW_CH6    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic       sensor_enable;
    logic [7:0] accumulate_limit;
    logic [6:0] drift_low_ch2;
    logic [6:0] drift_low_ch6;
  } cfg_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] status;
    logic [7:0] delta_two;
    logic [7:0] delta_six;
  } item_t;

  typedef struct packed {
    logic object_near;
    logic wood_mode;
    logic enter_wood;
    logic leave_wood;
    logic recalibrate;
  } result_t;

endpackage

// File: rtl/core/psmc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psmc_in_if / psmc_out_if
// Valid/ready channels for sensor samples and controller results.
// ----------------------------------------------------------------------------
interface psmc_in_if;
  logic       valid;
  logic       ready;
  logic [0:0] op;
  logic [7:0] status;
  logic [7:0] delta_two;
  logic [7:0] delta_six;

  modport source (output valid, output op, output status, output delta_two,
                  output delta_six, input ready);
  modport sink   (input valid, input op, input status, input delta_two,
                  input delta_six, output ready);
endinterface

interface psmc_out_if;
  logic valid;
  logic ready;
  logic object_near;
  logic wood_mode;
  logic enter_wood;
  logic leave_wood;
  logic recalibrate;

  modport source (output valid, output object_near, output wood_mode,
                  output enter_wood, output leave_wood, output recalibrate,
                  input ready);
  modport sink   (input valid, input object_near, input wood_mode,
                  input enter_wood, input leave_wood, input recalibrate,
                  output ready);
endinterface

// File: rtl/core/psmc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psmc_core
// Mode state and per-sample evaluation: detect, wood mode, drift counters.
// ----------------------------------------------------------------------------
module psmc_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  psmc_pkg::item_t  item_i,
  input  psmc_pkg::cfg_t   cfg_i,
  output psmc_pkg::result_t result_o
);
  import psmc_pkg::*;

  logic       wood_q, wood_d;
  logic [1:0] ovf_q, ovf_d;
  logic [7:0] cnt2_q, cnt2_d;
  logic [7:0] cnt6_q, cnt6_d;
  logic       det_q, det_d;

  logic       t2, t6, o2, o6;
  logic       drift2, drift6, idle, back;
  logic [7:0] cnt2_b, cnt6_b;
  logic       enter, leave, recal;

  always_comb begin
    t2 = (item_i.status == StatCh2) || (item_i.status == StatBoth);
    t6 = (item_i.status == StatCh6) || (item_i.status == StatBoth);
    o2 = t2 && (item_i.delta_two == DeltaSat);
    o6 = t6 && (item_i.delta_six == DeltaSat);

    drift2 = (item_i.delta_two >= {1'b0, cfg_i.drift_low_ch2}) &&
             (item_i.delta_two <= DriftHigh);
    drift6 = (item_i.delta_six >= {1'b0, cfg_i.drift_low_ch6}) &&
             (item_i.delta_six <= DriftHigh);
    cnt2_b = (drift2 && cnt2_q != CountMax) ? cnt2_q + 8'd1 : cnt2_q;
    cnt6_b = (drift6 && cnt6_q != CountMax) ? cnt6_q + 8'd1 : cnt6_q;

    idle = ((item_i.delta_two == DeltaIdleLo) || (item_i.delta_two == DeltaIdleHi)) &&
           ((item_i.delta_six == DeltaIdleLo) || (item_i.delta_six == DeltaIdleHi));
    back = (ovf_q[0] && item_i.delta_two > ReturnLow && item_i.delta_two <= DeltaSat) ||
           (ovf_q[1] && item_i.delta_six > ReturnLow && item_i.delta_six <= DeltaSat);

    wood_d = wood_q;
    ovf_d  = ovf_q;
    cnt2_d = cnt2_q;
    cnt6_d = cnt6_q;
    det_d  = det_q;
    enter  = 1'b0;
    leave  = 1'b0;
    recal  = 1'b0;

    if (cfg_i.sensor_enable) begin
      if (item_i.op == OP_ALERT && !wood_q) begin
        det_d = t2 || t6;
        if (o2 || o6) begin
          enter  = 1'b1;
          wood_d = 1'b1;
          ovf_d  = {t6, t2};
          cnt2_d = '0;
          cnt6_d = '0;
        end else if (cnt2_b >= cfg_i.accumulate_limit ||
                     cnt6_b >= cfg_i.accumulate_limit) begin
          recal  = 1'b1;
          cnt2_d = '0;
          cnt6_d = '0;
        end else begin
          cnt2_d = cnt2_b;
          cnt6_d = cnt6_b;
        end
      end else if (item_i.op == OP_CHECK && wood_q) begin
        if (idle || back) begin
          leave  = 1'b1;
          wood_d = 1'b0;
        end
      end
    end

    result_o.object_near = cfg_i.sensor_enable & det_d;
    result_o.wood_mode   = wood_d;
    result_o.enter_wood  = enter;
    result_o.leave_wood  = leave;
    result_o.recalibrate = recal;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wood_q <= 1'b0;
      ovf_q  <= '0;
      cnt2_q <= '0;
      cnt6_q <= '0;
      det_q  <= 1'b0;
    end else if (step_i) begin
      wood_q <= wood_d;
      ovf_q  <= ovf_d;
      cnt2_q <= cnt2_d;
      cnt6_q <= cnt6_d;
      det_q  <= det_d;
    end
  end

endmodule

// File: rtl/core/proximity_sensitivity_mode_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_sensitivity_mode_control
// Mode controller for a two-channel capacitive proximity sensor.
//
// Samples arrive on in_ch: op selects an alert sample or a periodic check
// tick, with the status byte and the channel two and six delta counts. Each
// transaction yields exactly one result on out_ch: object-detect flag, wood
// mode flag and the enter, leave and recalibrate pulses.
// The path from input transaction to result transaction is one input
// register, then the evaluation logic into the result register.
// Throughput is one transaction per cycle while out_ch is not stalled; the
// mode state updates as a sample moves from the input register into the
// result register. A stalled receiver holds the result register; one further
// sample waits in the input register, after which in_ch.ready drops.
// Reset clears the mode state, drift counters and both pipeline stages and
// loads the register defaults: enabled, limit 10, drift lows 8 and 10.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user
// must do so only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module proximity_sensitivity_mode_control (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psmc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [psmc_pkg::CfgDataW-1:0] cfg_wdata_i,
  psmc_in_if.sink                       in_ch,
  psmc_out_if.source                    out_ch
);
  import psmc_pkg::*;

  cfg_t    cfg_q;
  item_t   item_q;
  logic    s1_valid_q;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    out_adv, s1_adv, in_fire;

  assign out_adv  = !out_valid_q || out_ch.ready;
  assign s1_adv   = s1_valid_q && out_adv;
  assign in_ch.ready = !s1_valid_q || out_adv;
  assign in_fire  = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_enable    <= 1'b1;
      cfg_q.accumulate_limit <= 8'd10;
      cfg_q.drift_low_ch2    <= 7'd8;
      cfg_q.drift_low_ch6    <= 7'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SENSOR_ENABLE:    cfg_q.sensor_enable    <= cfg_wdata_i[0];
        CFG_ACCUMULATE_LIMIT: cfg_q.accumulate_limit <= cfg_wdata_i;
        CFG_DRIFT_LOW_CH2:    cfg_q.drift_low_ch2    <= cfg_wdata_i[6:0];
        CFG_DRIFT_LOW_CH6:    cfg_q.drift_low_ch6    <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_q <= in_ch.valid;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.op        <= op_e'(in_ch.op);
      item_q.status    <= in_ch.status;
      item_q.delta_two <= in_ch.delta_two;
      item_q.delta_six <= in_ch.delta_six;
    end
    if (s1_adv) begin
      res_q <= res_d;
    end
  end

  psmc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .result_o (res_d)
  );

  assign out_ch.valid       = out_valid_q;
  assign out_ch.object_near = res_q.object_near;
  assign out_ch.wood_mode   = res_q.wood_mode;
  assign out_ch.enter_wood  = res_q.enter_wood;
  assign out_ch.leave_wood  = res_q.leave_wood;
  assign out_ch.recalibrate = res_q.recalibrate;

  a_enter_sets_wood: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.enter_wood |-> out_ch.wood_mode)
    else $error("enter pulse without wood mode");

  a_leave_clears_wood: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.leave_wood |-> !out_ch.wood_mode)
    else $error("leave pulse with wood mode still set");

  a_pulses_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> $onehot0({out_ch.enter_wood, out_ch.leave_wood, out_ch.recalibrate}))
    else $error("more than one mode pulse in one result");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_adv |=> out_valid_q)
    else $error("advanced sample did not reach result register");

endmodule
